[hw/rtl/bch_enc_pkg.sv]
// bch_enc_pkg: shared widths, register indexes and result type for the
// bit-serial bch systematic encoder. no dependencies.
`default_nettype none

package bch_enc_pkg;

   localparam int MSG_LEN_W    = 8;
   localparam int PARITY_LEN_W = 7;
   localparam int TAPS_W       = 64;
   localparam int PARITY_W     = 64;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 5;

   // register index = paddr[4:3], registers sit on 8-byte boundaries
   localparam logic [1:0] REG_MSG_LEN    = 2'd0;
   localparam logic [1:0] REG_PARITY_LEN = 2'd1;
   localparam logic [1:0] REG_GEN_TAPS   = 2'd2;

   localparam logic [MSG_LEN_W-1:0]    MSG_LEN_RST    = 8'd7;
   localparam logic [PARITY_LEN_W-1:0] PARITY_LEN_RST = 7'd8;
   localparam logic [TAPS_W-1:0]       GEN_TAPS_RST   = 64'd232;

   typedef struct packed {
      logic                code_bit;
      logic [PARITY_W-1:0] parity_word;
      logic                parity_valid;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/bch_systematic_encoder_top.sv]
// bch_systematic_encoder_top: bit-serial systematic bch encoder, division
// register with parallel xor taps, apb-style register port. uses bch_enc_pkg.
// the result of an accepted bit is registered (result register, or skid).
// throughput: one message bit per cycle while req_ready is high; the window
// update is a single shift-and-xor step, so a bit can enter on every ready clock.
// a two-entry output stage (result register plus skid) keeps req_ready high
// while one result waits. synchronous active-high reset clears the window,
// bit counter and output flags and loads the register reset values.
`default_nettype none

module bch_systematic_encoder_top #(
   parameter int MAX_PARITY   = 64,
   parameter int MAX_CODE_LEN = 255
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // input channel
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire                                 req_msg_bit,
   // result channel
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_code_bit,
   output logic [bch_enc_pkg::PARITY_W-1:0]    rsp_parity_word,
   output logic                                rsp_parity_valid,
   // register port
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [bch_enc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire  [bch_enc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bch_enc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                pready
);
   import bch_enc_pkg::*;

   localparam int W = MAX_PARITY;

   // configuration registers
   logic [MSG_LEN_W-1:0]    msg_len_ff;
   logic [PARITY_LEN_W-1:0] parity_len_ff;
   logic [TAPS_W-1:0]       gen_taps_ff;

   // encoder state
   logic [W-1:0]            window_ff, window_in;
   logic [MSG_LEN_W-1:0]    bit_pos_ff, bit_pos_in;

   // output stage
   result_type              out_ff, out_in, skid_ff, skid_in, result;
   logic                    out_valid_ff, out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;

   logic                    accept, take, csr_write;
   logic [1:0]              reg_idx;
   logic [PARITY_LEN_W-1:0] plen_eff;
   logic [MSG_LEN_W-1:0]    mlen_eff;
   logic [W-1:0]            mask, win, win_next;
   logic                    feedback, msg_end;
   logic [MSG_LEN_W:0]      count;

   // ---------------- register port ----------------
   assign pready    = 1'b1;
   assign reg_idx   = paddr[4:3];
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_len_ff    <= MSG_LEN_RST;
         parity_len_ff <= PARITY_LEN_RST;
         gen_taps_ff   <= GEN_TAPS_RST;
      end else if (csr_write) begin
         case (reg_idx)
            REG_MSG_LEN:    msg_len_ff    <= pwdata[MSG_LEN_W-1:0];
            REG_PARITY_LEN: parity_len_ff <= pwdata[PARITY_LEN_W-1:0];
            REG_GEN_TAPS:   gen_taps_ff   <= pwdata[TAPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MSG_LEN:    prdata = CSR_DATA_W'(msg_len_ff);
         REG_PARITY_LEN: prdata = CSR_DATA_W'(parity_len_ff);
         REG_GEN_TAPS:   prdata = CSR_DATA_W'(gen_taps_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------- division step ----------------
   assign plen_eff = (parity_len_ff > PARITY_LEN_W'(MAX_PARITY)) ?
                     PARITY_LEN_W'(MAX_PARITY) : parity_len_ff;
   assign mlen_eff = (msg_len_ff > MSG_LEN_W'(MAX_CODE_LEN - 1)) ?
                     MSG_LEN_W'(MAX_CODE_LEN - 1) : msg_len_ff;

   always_comb begin
      for (int i = 0; i < W; i++) begin
         mask[i] = (PARITY_LEN_W'(i) < plen_eff);
      end
   end

   assign win      = window_ff & mask;
   assign feedback = req_msg_bit ^ win[0];
   assign win_next = ((win >> 1) ^ (feedback ? gen_taps_ff[W-1:0] : '0)) & mask;
   assign count    = {1'b0, bit_pos_ff} + (MSG_LEN_W+1)'(1);
   assign msg_end  = (count >= {1'b0, mlen_eff});

   always_comb begin
      result.code_bit     = req_msg_bit;
      result.parity_word  = msg_end ? PARITY_W'(win_next) : '0;
      result.parity_valid = msg_end;
   end

   assign accept = req_valid & req_ready;
   assign take   = out_valid_ff & rsp_ready;

   always_comb begin
      window_in  = window_ff;
      bit_pos_in = bit_pos_ff;
      if (accept) begin
         if (msg_end) begin
            window_in  = '0;
            bit_pos_in = '0;
         end else begin
            window_in  = win_next;
            bit_pos_in = count[MSG_LEN_W-1:0];
         end
      end
   end

   // ---------------- output register and skid ----------------
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         bit_pos_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         window_ff     <= window_in;
         bit_pos_ff    <= bit_pos_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_ready        = ~skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_code_bit     = out_ff.code_bit;
   assign rsp_parity_word  = out_ff.parity_word;
   assign rsp_parity_valid = out_ff.parity_valid;

endmodule

`default_nettype wire

[hw/rtl/bch_enc_checker.sv]
// bch_enc_checker: port-level assertions for bch_systematic_encoder_top,
// attached by bind. uses bch_enc_pkg for port widths.
`default_nettype none

module bch_enc_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_ready,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire                                rsp_parity_valid,
   input wire [bch_enc_pkg::PARITY_W-1:0]    rsp_parity_word
);
   import bch_enc_pkg::*;

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("output stage not empty after reset");

   // input back-pressure only while a result is already waiting
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no pending result");

   // parity word is zero unless this transaction ends a message
   a_parity_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_parity_valid) |-> (rsp_parity_word == '0))
      else $error("parity word nonzero without parity_valid");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped before transaction");

endmodule

bind bch_systematic_encoder_top bch_enc_checker u_bch_enc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_parity_valid (rsp_parity_valid),
   .rsp_parity_word  (rsp_parity_word)
);

`default_nettype wire

[tb/tb_top.sv]
// tb_top: self-checking bench for the bit-serial bch systematic encoder.
// holds a division-register model in a small class, drives the request,
// response and register ports; needs bch_enc_pkg and bch_systematic_encoder_top.
`timescale 1ns / 100ps

module tb_top;

   import bch_enc_pkg::*;

   localparam int MAX_PARITY   = 64;
   localparam int MAX_CODE_LEN = 255;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_PHASES   = 15;

   // division register model: remainder window, bit counter, register copies
   class bch_codeword_model;
      logic [MSG_LEN_W-1:0]    msg_len;
      logic [PARITY_LEN_W-1:0] parity_len;
      logic [TAPS_W-1:0]       gen_taps;
      logic [PARITY_W-1:0]     window;
      int                      bits_taken;
      int                      errors;
      result_type              expected_codeword[$];

      function new();
         msg_len    = MSG_LEN_RST;
         parity_len = PARITY_LEN_RST;
         gen_taps   = GEN_TAPS_RST;
         window     = '0;
         bits_taken = 0;
         errors     = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_MSG_LEN:    msg_len    = value[MSG_LEN_W-1:0];
            REG_PARITY_LEN: parity_len = value[PARITY_LEN_W-1:0];
            REG_GEN_TAPS:   gen_taps   = value[TAPS_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_codeword.size();
      endfunction

      function void take_msg_bit(logic msg_bit);
         logic [PARITY_W-1:0] mask;
         logic [PARITY_W-1:0] win;
         logic                feedback;
         int                  window_len;
         int                  msg_limit;
         int                  count;
         result_type          res;
         window_len = (parity_len > MAX_PARITY) ? MAX_PARITY : parity_len;
         mask = (window_len >= 64) ? '1 : ((64'd1 << window_len) - 64'd1);
         win = window & mask;
         feedback = msg_bit ^ win[0];
         win = win >> 1;
         if (feedback) begin
            win = win ^ gen_taps;
         end
         win = win & mask;
         msg_limit = (msg_len > MAX_CODE_LEN - 1) ? MAX_CODE_LEN - 1 : msg_len;
         count = (bits_taken & 8'hFF) + 1;
         res.code_bit = msg_bit;
         // message ends once the count reaches the current length, even a lowered one
         if (count >= msg_limit) begin
            res.parity_word  = win;
            res.parity_valid = 1'b1;
            window = '0;
            bits_taken = 0;
         end else begin
            res.parity_word  = '0;
            res.parity_valid = 1'b0;
            window = win;
            bits_taken = count & 8'hFF;
         end
         expected_codeword.insert(expected_codeword.size(), res);
      endfunction

      function void compare_result(logic code_bit, logic [PARITY_W-1:0] parity_word,
                                   logic parity_valid);
         result_type want;
         if (expected_codeword.size() == 0) begin
            $error("rsp transaction with no expected codeword bit");
            errors++;
            return;
         end
         want = expected_codeword.pop_front();
         if (code_bit !== want.code_bit) begin
            $error("code_bit: expected %0b, actual %0b", want.code_bit, code_bit);
            errors++;
         end
         if (parity_word !== want.parity_word) begin
            $error("parity_word: expected %h, actual %h", want.parity_word, parity_word);
            errors++;
         end
         if (parity_valid !== want.parity_valid) begin
            $error("parity_valid: expected %0b, actual %0b", want.parity_valid,
                   parity_valid);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_msg_bit;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_code_bit;
   logic [PARITY_W-1:0]   rsp_parity_word;
   logic                  rsp_parity_valid;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bch_codeword_model model = new();
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int          stall_cycles;

   bch_systematic_encoder_top #(
      .MAX_PARITY   (MAX_PARITY),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_msg_bit      (req_msg_bit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_bit     (rsp_code_bit),
      .rsp_parity_word  (rsp_parity_word),
      .rsp_parity_valid (rsp_parity_valid),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // outputs are stable at the falling edge, so the handshake seen here
   // completes at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         model.compare_result(rsp_code_bit, rsp_parity_word, rsp_parity_valid);
      end
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(negedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   // called at a rising edge, returns at the edge that accepts the transaction
   task automatic send_msg_bit(input logic msg_bit);
      logic taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_msg_bit <= msg_bit;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      model.take_msg_bit(msg_bit);
   endtask

   task automatic send_random_bits(input int count);
      for (int i = 0; i < count; i++) begin
         send_msg_bit(1'($urandom_range(1)));
      end
      req_valid <= 1'b0;
   endtask

   task automatic send_pattern(input logic [31:0] pattern, input int count);
      for (int i = count - 1; i >= 0; i--) begin
         send_msg_bit(pattern[i]);
      end
      req_valid <= 1'b0;
   endtask

   // registers change only once every outstanding result has come back
   task automatic write_csr(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      while (model.pending() != 0) begin
         @(posedge clock);
      end
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      model.set_register(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_setting(input logic [7:0] msg_len, input logic [6:0] parity_len,
                               input logic [63:0] taps);
      write_csr(REG_MSG_LEN, {56'd0, msg_len});
      write_csr(REG_PARITY_LEN, {57'd0, parity_len});
      write_csr(REG_GEN_TAPS, taps);
   endtask

   task automatic run_phase(input int phase);
      logic [63:0] taps;
      int          count;
      taps  = {$urandom, $urandom};
      count = 48;
      case (phase)
         0:  load_setting(8'd1, 7'd1, 64'd1);
         1:  load_setting(8'd0, 7'd64, '1);
         2:  load_setting(8'd8, 7'd127, taps);
         3:  load_setting(8'($urandom_range(2, 20)), 7'd0, taps);
         4: begin
            // oversized length clamps to 254
            load_setting(8'd255, 7'($urandom_range(1, 64)), taps);
            count = 260;
         end
         9:  load_setting(8'($urandom_range(1, 24)), 7'($urandom_range(65, 127)), taps);
         10: load_setting(8'd15, 7'd64, 64'd0);
         11: begin
            load_setting(8'd254, 7'd64, taps);
            count = 260;
         end
         default: load_setting(8'($urandom_range(1, 24)), 7'($urandom_range(1, 64)), taps);
      endcase
      send_random_bits(count);
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_msg_bit   = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      send_idle_pct = 20;
      recv_idle_pct = 74;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: one mixed message, then one of all ones
      send_pattern(32'b1011001, 7);
      send_pattern(32'b1111111, 7);
      // empty window, every bit ends a message
      load_setting(8'd0, 7'd0, 64'd5);
      send_pattern(32'b101, 3);
      // oversized window with every tap set
      load_setting(8'd1, 7'd127, '1);
      send_pattern(32'b110, 3);
      // lower the length while a message is under way
      load_setting(8'd3, 7'd64, 64'h8000_0000_0000_0001);
      send_pattern(32'b11, 2);
      write_csr(REG_MSG_LEN, 64'd1);
      send_pattern(32'b101, 3);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == 5) begin
            send_idle_pct = 74;
            recv_idle_pct = 20;
         end else if (phase == 10) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_phase(phase);
      end

      while (model.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (model.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/bch_enc_pkg.sv
hw/rtl/bch_systematic_encoder_top.sv
hw/rtl/bch_enc_checker.sv
tb/tb_top.sv
